### src/tht_pkg.sv
package tht_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_LIST_DEF    = 64;

    localparam int KEY_W = 44;
    localparam int PAY_W = 52;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_LIST   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS0,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

### src/timetable_hop_table.sv
// channel  direction  handshake                  payload
// s        in         i_s_tvalid / o_s_tready    i_s_tdata, i_s_tuser (opcode)
// m        out        o_m_tvalid / i_m_tready    o_m_tdata, o_m_tuser (status), o_m_tlast
//
// one item is taken at a time; insert walks the table down from the top,
// moving one entry a cycle; find and list read the key/payload memories one entry a
// cycle, unless the output side stalls
// reset clears the entry count and the control state; the memories need no clearing
// a stalled result holds in the output register while the scan re-reads the same entry
module timetable_hop_table
    import tht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_LIST    = MAX_LIST_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // service, route, start_time, end_time, dest_stop, trip, max_count, zero pad
    input  logic [103:0] i_s_tdata,
    // opcode
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // hop_start, hop_end, hop_dest, hop_trip, route_out
    output logic [87:0]  o_m_tdata,
    // status
    output logic [1:0]   o_m_tuser,
    output logic         o_m_tlast
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0] r_kmem [TABLE_DEPTH];
    logic [PAY_W-1:0] r_pmem [TABLE_DEPTH];
    logic [KEY_W-1:0] r_qkey;
    logic [PAY_W-1:0] r_qpay;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_qidx, n_qidx;
    logic          r_qv, n_qv;
    t_opcode       r_op, n_op;
    logic [7:0]    r_svc, n_svc;
    logic [15:0]   r_rte, n_rte;
    logic [19:0]   r_t, n_t;
    logic [PAY_W-1:0] r_pay, n_pay;
    logic [6:0]    r_lim, n_lim;
    logic [6:0]    r_k, n_k;
    logic          r_have, n_have;
    logic [15:0]   r_prev, n_prev;
    t_status       r_dstat, n_dstat;
    logic          r_pv, n_pv;
    logic [19:0]   r_pstart, n_pstart;
    logic [PAY_W-1:0] r_ppay, n_ppay;
    logic [15:0]   r_proute, n_proute;
    logic          r_ov, n_ov;
    t_status       r_ost, n_ost;
    logic [19:0]   r_ostart, n_ostart;
    logic [PAY_W-1:0] r_opay, n_opay;
    logic [15:0]   r_oroute, n_oroute;
    logic          r_olast, n_olast;

    logic [AW-1:0]    rd_addr;
    logic             w_en;
    logic [AW-1:0]    w_addr;
    logic [KEY_W-1:0] w_key;
    logic [PAY_W-1:0] w_pay;

    logic [KEY_W-1:0] new_key;
    logic             out_free, match, take, stall;
    logic [6:0]       in_max;

    assign new_key  = {r_svc, r_rte, r_t};
    assign out_free = !r_ov || i_m_tready;
    assign in_max   = i_s_tdata[102:96];

    always_comb begin
        if (r_op == OP_FIND) begin
            match = (r_qkey[43:20] == {r_svc, r_rte}) && (r_qkey[19:0] >= r_t);
        end else begin
            match = (r_qkey[43:36] == r_svc) && (!r_have || r_qkey[35:20] != r_prev);
        end
    end

    assign take  = r_qv && (r_k < r_lim) && match;
    assign stall = take && r_pv && !out_free;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kmem[w_addr] <= w_key;
            r_pmem[w_addr] <= w_pay;
        end
        r_qkey <= r_kmem[rd_addr];
        r_qpay <= r_pmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_qv    <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_k     <= '0;
            r_lim   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_qv    <= n_qv;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
            r_k     <= n_k;
            r_lim   <= n_lim;
        end
        r_rd     <= n_rd;
        r_qidx   <= n_qidx;
        r_op     <= n_op;
        r_svc    <= n_svc;
        r_rte    <= n_rte;
        r_t      <= n_t;
        r_pay    <= n_pay;
        r_have   <= n_have;
        r_prev   <= n_prev;
        r_dstat  <= n_dstat;
        r_pstart <= n_pstart;
        r_ppay   <= n_ppay;
        r_proute <= n_proute;
        r_ost    <= n_ost;
        r_ostart <= n_ostart;
        r_opay   <= n_opay;
        r_oroute <= n_oroute;
        r_olast  <= n_olast;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rd     = r_rd;
        n_qidx   = r_qidx;
        n_qv     = r_qv;
        n_op     = r_op;
        n_svc    = r_svc;
        n_rte    = r_rte;
        n_t      = r_t;
        n_pay    = r_pay;
        n_lim    = r_lim;
        n_k      = r_k;
        n_have   = r_have;
        n_prev   = r_prev;
        n_dstat  = r_dstat;
        n_pv     = r_pv;
        n_pstart = r_pstart;
        n_ppay   = r_ppay;
        n_proute = r_proute;
        n_ov     = r_ov && !i_m_tready;
        n_ost    = r_ost;
        n_ostart = r_ostart;
        n_opay   = r_opay;
        n_oroute = r_oroute;
        n_olast  = r_olast;
        rd_addr  = r_rd[AW-1:0];
        w_en     = 1'b0;
        w_addr   = '0;
        w_key    = new_key;
        w_pay    = r_pay;
        o_s_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_op    = t_opcode'(i_s_tuser);
                    n_svc   = i_s_tdata[7:0];
                    n_rte   = i_s_tdata[23:8];
                    n_t     = i_s_tdata[43:24];
                    n_pay   = {i_s_tdata[63:44], i_s_tdata[79:64], i_s_tdata[95:80]};
                    n_lim   = (in_max > 7'(MAX_LIST)) ? 7'(MAX_LIST) : in_max;
                    n_k     = '0;
                    n_pv    = 1'b0;
                    n_have  = 1'b0;
                    n_rd    = '0;
                    n_qv    = 1'b0;
                    unique case (t_opcode'(i_s_tuser))
                        OP_INSERT: begin
                            if (r_cnt >= CW'(TABLE_DEPTH)) begin
                                n_dstat = ST_FULL;
                                n_state = S_DONE;
                            end else if (r_cnt == '0) begin
                                n_state = S_INS0;
                            end else begin
                                rd_addr = AW'(r_cnt - 1'b1);
                                n_qidx  = r_cnt - 1'b1;
                                n_qv    = 1'b1;
                                n_state = S_INS;
                            end
                        end
                        OP_FIND: begin
                            n_state = S_SCAN;
                        end
                        OP_LIST: begin
                            n_lim   = 7'(MAX_LIST);
                            n_state = S_SCAN;
                        end
                        OP_NONE: begin
                            n_state = S_IDLE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                w_en   = 1'b1;
                w_addr = AW'(r_qidx + 1'b1);
                if (r_qkey > new_key) begin
                    w_key = r_qkey;
                    w_pay = r_qpay;
                    if (r_qidx == '0) begin
                        n_qv    = 1'b0;
                        n_state = S_INS0;
                    end else begin
                        rd_addr = AW'(r_qidx - 1'b1);
                        n_qidx  = r_qidx - 1'b1;
                    end
                end else begin
                    n_qv    = 1'b0;
                    n_cnt   = r_cnt + 1'b1;
                    n_dstat = ST_OK;
                    n_state = S_DONE;
                end
            end
            S_INS0: begin
                w_en    = 1'b1;
                w_addr  = '0;
                n_cnt   = r_cnt + 1'b1;
                n_dstat = ST_OK;
                n_state = S_DONE;
            end
            S_SCAN: begin
                if ((r_k >= r_lim) || (r_rd == r_cnt && !r_qv)) begin
                    n_qv    = 1'b0;
                    n_dstat = ST_NONE;
                    n_state = S_DONE;
                end else if (stall) begin
                    rd_addr = AW'(r_rd - 1'b1);
                end else begin
                    if (take) begin
                        if (r_pv) begin
                            n_ov     = 1'b1;
                            n_ost    = ST_OK;
                            n_ostart = r_pstart;
                            n_opay   = r_ppay;
                            n_oroute = r_proute;
                            n_olast  = 1'b0;
                        end
                        n_pv   = 1'b1;
                        n_k    = r_k + 1'b1;
                        n_have = 1'b1;
                        n_prev = r_qkey[35:20];
                        if (r_op == OP_FIND) begin
                            n_pstart = r_qkey[19:0];
                            n_ppay   = r_qpay;
                            n_proute = r_rte;
                        end else begin
                            n_pstart = '0;
                            n_ppay   = '0;
                            n_proute = r_qkey[35:20];
                        end
                    end
                    if (r_rd < r_cnt && n_k < r_lim) begin
                        n_qv = 1'b1;
                        n_rd = r_rd + 1'b1;
                    end else begin
                        n_qv = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_olast = 1'b1;
                    if (r_pv) begin
                        n_ost    = ST_OK;
                        n_ostart = r_pstart;
                        n_opay   = r_ppay;
                        n_oroute = r_proute;
                    end else begin
                        n_ost    = r_dstat;
                        n_ostart = '0;
                        n_opay   = '0;
                        n_oroute = '0;
                    end
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_oroute, r_opay[15:0], r_opay[31:16], r_opay[51:32], r_ostart};
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ost != ST_OK) |-> r_olast)
        else $error("error status without last");

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= r_lim))
        else $error("scan emitted more than its limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_tready) |=> (r_ov && $stable(o_m_tdata) && $stable(r_olast)))
        else $error("stalled result changed");

endmodule

### tb/sv/tb_timetable_hop_table.sv
module tb_timetable_hop_table;
    import tht_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int LIST_MAX   = MAX_LIST_DEF;
    localparam int CYCLE_CAP  = 6000000;
    localparam int N_RANDOM   = 340;
    localparam int SHOW_ERRS  = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  service;
        logic [15:0] route;
        logic [19:0] depart;
        logic [19:0] arrive;
        logic [15:0] dest_stop;
        logic [15:0] trip;
        logic [6:0]  max_count;
    } t_hop_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] hop_start;
        logic [19:0] hop_end;
        logic [15:0] hop_dest;
        logic [15:0] hop_trip;
        logic [15:0] route_out;
        logic        last;
    } t_hop_reply;

    class hop_scoreboard;
        logic [43:0]  keys [DEPTH];
        logic [51:0]  pays [DEPTH];
        int           count;
        t_hop_reply   pending [$];
        int           errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void push_reply(logic [1:0] st, logic [43:0] key, logic [51:0] pay,
                                 logic [15:0] rte, logic lst);
            t_hop_reply r;
            r.status    = st;
            r.hop_start = key[19:0];
            r.hop_end   = pay[51:32];
            r.hop_dest  = pay[31:16];
            r.hop_trip  = pay[15:0];
            r.route_out = rte;
            r.last      = lst;
            pending = {pending, r};
        endfunction

        function void note_input(t_hop_cmd c);
            logic [43:0] key, lo, hi;
            logic [15:0] prev;
            bit          have;
            int          pos, lim, k;
            key  = {c.service, c.route, c.depart};
            k    = 0;
            have = 0;
            prev = '0;
            case (c.op)
                OP_INSERT: begin
                    if (count >= DEPTH) begin
                        push_reply(ST_FULL, '0, '0, '0, 1'b1);
                    end else begin
                        pos = count;
                        for (int i = 0; i < count; i++) begin
                            if (keys[i] > key) begin
                                pos = i;
                                break;
                            end
                        end
                        for (int i = count; i > pos; i--) begin
                            keys[i] = keys[i-1];
                            pays[i] = pays[i-1];
                        end
                        keys[pos] = key;
                        pays[pos] = {c.arrive, c.dest_stop, c.trip};
                        count++;
                        push_reply(ST_OK, '0, '0, '0, 1'b1);
                    end
                    return;
                end
                OP_FIND: begin
                    lim = (c.max_count > LIST_MAX) ? LIST_MAX : c.max_count;
                    lo  = key;
                    hi  = {c.service, c.route, 20'hFFFFF};
                    for (int i = 0; i < count && k < lim; i++) begin
                        if (keys[i] >= lo && keys[i] <= hi) begin
                            push_reply(ST_OK, keys[i], pays[i], c.route, 1'b0);
                            k++;
                        end
                    end
                end
                OP_LIST: begin
                    for (int i = 0; i < count && k < LIST_MAX; i++) begin
                        if (keys[i][43:36] == c.service &&
                            !(have && keys[i][35:20] == prev)) begin
                            have = 1;
                            prev = keys[i][35:20];
                            push_reply(ST_OK, '0, '0, prev, 1'b0);
                            k++;
                        end
                    end
                end
                default: return;
            endcase
            if (k == 0) push_reply(ST_NONE, '0, '0, '0, 1'b1);
            else pending[pending.size()-1].last = 1'b1;
        endfunction

        function void check(t_hop_reply got);
            t_hop_reply want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= SHOW_ERRS) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= SHOW_ERRS) begin
                    $display("mismatch: expected st=%0d s=%h e=%h d=%h t=%h r=%h l=%b",
                             want.status, want.hop_start, want.hop_end, want.hop_dest,
                             want.hop_trip, want.route_out, want.last);
                    $display("          got      st=%0d s=%h e=%h d=%h t=%h r=%h l=%b",
                             got.status, got.hop_start, got.hop_end, got.hop_dest,
                             got.hop_trip, got.route_out, got.last);
                end
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // service, route, start_time, end_time, dest_stop, trip, max_count, zero pad
    logic [103:0] i_s_tdata = '0;
    // opcode
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // hop_start, hop_end, hop_dest, hop_trip, route_out
    logic [87:0]  o_m_tdata;
    // status
    logic [1:0]   o_m_tuser;
    logic         o_m_tlast;

    hop_scoreboard sb = new();
    int            burst_left = 0;
    int            cycles = 0;
    int            stall_mode = 0;
    int            stall_left = 0;

    timetable_hop_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: phases of always-ready, random stalls and long stalls
    always @(posedge i_clk) begin
        t_hop_reply got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata[19:0], o_m_tdata[39:20], o_m_tdata[55:40],
                   o_m_tdata[71:56], o_m_tdata[87:72], o_m_tlast};
            sb.check(got);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 200);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_cmd(t_hop_cmd c);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= c.op;
        i_s_tdata  <= {1'b0, c.max_count, c.trip, c.dest_stop, c.arrive,
                       c.depart, c.route, c.service};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(c);
    endtask

    function automatic t_hop_cmd mk(logic [1:0] op, logic [7:0] svc, logic [15:0] rte,
                                    logic [19:0] t, logic [6:0] mc);
        t_hop_cmd c;
        c.op         = op;
        c.service    = svc;
        c.route      = rte;
        c.depart     = t;
        c.arrive     = 20'($urandom_range(0, 20'hFFFFF));
        c.dest_stop  = 16'($urandom_range(0, 16'hFFFF));
        c.trip       = 16'($urandom_range(0, 16'hFFFF));
        c.max_count  = mc;
        return c;
    endfunction

    function automatic t_hop_cmd rand_cmd();
        t_hop_cmd    c;
        int          sel;
        logic [1:0]  op;
        logic [7:0]  svc;
        logic [15:0] rte;
        logic [19:0] t;
        logic [6:0]  mc;
        sel = $urandom_range(0, 99);
        op  = (sel < 50) ? OP_INSERT : (sel < 78) ? OP_FIND : (sel < 97) ? OP_LIST : OP_NONE;
        svc = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0:       rte = 16'hFFFF;
            1:       rte = 16'($urandom_range(0, 16'hFFFF));
            default: rte = 16'($urandom_range(0, 2));
        endcase
        t  = ($urandom_range(0, 2) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                         : 20'($urandom_range(0, 40) * 100);
        mc = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(1, 8));
        c  = mk(op, svc, rte, t, mc);
        return c;
    endfunction

    initial begin
        t_hop_cmd c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(mk(OP_FIND, 8'd1, 16'd1, 20'd0, 7'd4));
        send_cmd(mk(OP_LIST, 8'd1, 16'd0, 20'd0, 7'd1));
        send_cmd(mk(OP_INSERT, 8'd0, 16'd0, 20'd0, 7'd0));
        c = mk(OP_INSERT, 8'hFF, 16'hFFFF, 20'hFFFFF, 7'h7F);
        c.arrive = 20'hFFFFF; c.dest_stop = 16'hFFFF; c.trip = 16'hFFFF;
        send_cmd(c);
        send_cmd(mk(OP_INSERT, 8'd1, 16'd1, 20'd100, 7'd0));
        send_cmd(mk(OP_INSERT, 8'd1, 16'd1, 20'd100, 7'd0));
        send_cmd(mk(OP_INSERT, 8'd1, 16'd1, 20'd50, 7'd0));
        send_cmd(mk(OP_INSERT, 8'd1, 16'd1, 20'd100, 7'd0));
        send_cmd(mk(OP_INSERT, 8'd1, 16'd3, 20'd10, 7'd0));
        send_cmd(mk(OP_FIND, 8'd1, 16'd1, 20'd100, 7'd64));
        send_cmd(mk(OP_FIND, 8'd1, 16'd1, 20'd0, 7'd0));
        send_cmd(mk(OP_FIND, 8'd1, 16'd1, 20'd0, 7'd127));
        send_cmd(mk(OP_FIND, 8'd1, 16'd1, 20'd0, 7'd1));
        send_cmd(mk(OP_FIND, 8'd1, 16'd1, 20'd101, 7'd5));
        send_cmd(mk(OP_FIND, 8'd1, 16'd2, 20'd0, 7'd5));
        send_cmd(mk(OP_FIND, 8'hFF, 16'hFFFF, 20'hFFFFF, 7'd3));
        send_cmd(mk(OP_FIND, 8'd0, 16'd0, 20'd0, 7'd3));
        send_cmd(mk(OP_LIST, 8'd1, 16'd0, 20'd0, 7'd0));
        send_cmd(mk(OP_LIST, 8'd200, 16'd0, 20'd0, 7'd0));
        send_cmd(mk(OP_LIST, 8'hFF, 16'd0, 20'd0, 7'd0));
        send_cmd(mk(OP_NONE, 8'd1, 16'd1, 20'd0, 7'd5));
        send_cmd(mk(OP_FIND, 8'd1, 16'd3, 20'd0, 7'd5));

        for (int n = 0; n < N_RANDOM; n++) send_cmd(rand_cmd());

        send_cmd(mk(OP_INSERT, 8'd9, 16'd5, 20'd7, 7'd0));
        send_cmd(mk(OP_INSERT, 8'd0, 16'd0, 20'd0, 7'd0));
        send_cmd(mk(OP_LIST, 8'd1, 16'd0, 20'd0, 7'd0));
        send_cmd(mk(OP_FIND, 8'd9, 16'd5, 20'd0, 7'd127));
        send_cmd(mk(OP_FIND, 8'd1, 16'd1, 20'h80000, 7'd64));
        send_cmd(mk(OP_FIND, 8'd1, 16'd1, 20'd0, 7'd10));
        send_cmd(mk(OP_INSERT, 8'hFF, 16'hFFFF, 20'hFFFFF, 7'd0));
        i_s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * DEPTH + 50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
